FILE: design/esud_pkg.sv
// ----------------------------------------------------------------------------
// esud_pkg: shared types and constants for epoch seconds to utc date
// command and status structs, reciprocal constants, month start table, helpers
// ----------------------------------------------------------------------------
package esud_pkg;

  localparam int unsigned SecsPerDay   = 86400;
  localparam int unsigned SecsPerHour  = 3600;
  localparam int unsigned SecsPerMin   = 60;
  localparam int unsigned DaysPerWeek  = 7;

  // floor(x * recip / 2**shift) is exact over each operand range
  // day: (secs >> 7) / 675, 25 bit operand, shift 35
  localparam logic [25:0] DayRecip     = 26'd50903317;
  // week: (days + 4) / 7, 16 bit operand, shift 19
  localparam logic [16:0] WeekRecip    = 17'd74899;
  // hour: (tod >> 4) / 225, 13 bit operand, shift 21
  localparam logic [13:0] HourRecip    = 14'd9321;
  // minute: (rem >> 2) / 15, 10 bit operand, shift 14
  localparam logic [10:0] MinRecip     = 11'd1093;

  localparam logic [11:0] EpochYear    = 12'd1970;
  localparam logic [6:0]  EpochYear100 = 7'd70;
  localparam logic [8:0]  EpochYear400 = 9'd370;
  localparam logic [6:0]  Cycle100Last = 7'd99;
  localparam logic [8:0]  Cycle400Last = 9'd399;
  localparam logic [8:0]  YearLen      = 9'd365;
  localparam logic [8:0]  LeapYearLen  = 9'd366;
  localparam logic [8:0]  LastNoLeapDay = 9'd58;
  localparam logic [8:0]  LeapDay      = 9'd59;
  localparam logic [3:0]  WdayOffset   = 4'd4;
  localparam int unsigned NumMonths    = 12;

  typedef struct packed {
    logic load;
    logic day_div;
    logic tod_split;
    logic hour_div;
    logic min_rem;
    logic min_div;
    logic to_year;
    logic year_step;
    logic finish;
  } esud_cmd_t;

  typedef struct packed {
    logic year_done;
  } esud_sts_t;

  function automatic logic [8:0] month_start(input logic [3:0] m);
    case (m)
      4'd0:    month_start = 9'd0;
      4'd1:    month_start = 9'd31;
      4'd2:    month_start = 9'd59;
      4'd3:    month_start = 9'd90;
      4'd4:    month_start = 9'd120;
      4'd5:    month_start = 9'd151;
      4'd6:    month_start = 9'd181;
      4'd7:    month_start = 9'd212;
      4'd8:    month_start = 9'd243;
      4'd9:    month_start = 9'd273;
      4'd10:   month_start = 9'd304;
      4'd11:   month_start = 9'd334;
      default: month_start = 9'd0;
    endcase
  endfunction

  // zero based month: number of later month starts at or below the day
  function automatic logic [3:0] month_index(input logic [8:0] d);
    logic [3:0] idx;
    idx = 4'd0;
    for (int i = 1; i < NumMonths; i++) begin
      if (month_start(4'(i)) <= d) idx = idx + 4'd1;
    end
    month_index = idx;
  endfunction

endpackage

FILE: design/epoch_seconds_to_utc_date.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_utc_date: unsigned epoch seconds to utc calendar date
//
// input: drive in_epoch_seconds and raise start; the beat is taken at a
// rising edge where start is high and busy is low. busy stays high while
// the conversion runs.
// output: out_valid is high for exactly one cycle with all out_ fields
// valid; the receiver takes the beat in that cycle and cannot stall it.
// steps: six steps split day, hour, minute and second by reciprocal
// multiplies, the year walk takes one year per cycle from 1970 until the
// remaining days fit in the current year, and the month lookup is the
// last registered step.
// overlap: none; no new start is taken while busy, and a new start is
// taken in the out_valid cycle.
// reset: synchronous, active low; returns the controller to idle, drops
// busy and out_valid. no state survives between items.
// ----------------------------------------------------------------------------
module epoch_seconds_to_utc_date (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  output logic [5:0]  out_second,
  output logic [5:0]  out_minute,
  output logic [4:0]  out_hour,
  output logic [2:0]  out_weekday,
  output logic [11:0] out_calendar_year,
  output logic [8:0]  out_day_of_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day_of_month
);

  esud_pkg::esud_cmd_t cmd;
  esud_pkg::esud_sts_t sts;

  esud_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (out_valid)
  );

  esud_dp u_dp (
    .clk              (clk),
    .cmd              (cmd),
    .in_epoch_seconds (in_epoch_seconds),
    .sts              (sts),
    .second           (out_second),
    .minute           (out_minute),
    .hour             (out_hour),
    .weekday          (out_weekday),
    .calendar_year    (out_calendar_year),
    .day_of_year      (out_day_of_year),
    .month            (out_month),
    .day_of_month     (out_day_of_month)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result strobe outside end of conversion");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month >= 4'd1 && out_month <= 4'd12 &&
                   out_day_of_month >= 5'd1 && out_day_of_month <= 5'd31 &&
                   out_day_of_year <= 9'd365))
    else $error("date field out of range");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hour <= 5'd23 && out_minute <= 6'd59 &&
                   out_second <= 6'd59 && out_weekday <= 3'd6))
    else $error("time field out of range");

endmodule

FILE: design/esud_dp.sv
// ----------------------------------------------------------------------------
// esud_dp: datapath
// reciprocal multiply splits for day, hour and minute, weekday residue,
// year walk with century counters, month and day lookup
// ----------------------------------------------------------------------------
module esud_dp (
  input  logic                 clk,
  input  esud_pkg::esud_cmd_t  cmd,
  input  logic [31:0]          in_epoch_seconds,
  output esud_pkg::esud_sts_t  sts,
  output logic [5:0]           second,
  output logic [5:0]           minute,
  output logic [4:0]           hour,
  output logic [2:0]           weekday,
  output logic [11:0]          calendar_year,
  output logic [8:0]           day_of_year,
  output logic [3:0]           month,
  output logic [4:0]           day_of_month
);

  logic [31:0] secs_r;
  logic [15:0] days_r;
  logic [16:0] tod_r;
  logic [13:0] wq_r;
  logic [11:0] mrem_r;
  logic [2:0]  wday_r;
  logic [4:0]  hour_r;
  logic [5:0]  min_r;
  logic [5:0]  sec_r;
  logic [11:0] year_r;
  logic [6:0]  y100_r;
  logic [8:0]  y400_r;
  logic [3:0]  month_r;
  logic [4:0]  mday_r;

  logic [50:0] day_prod;
  logic [31:0] day_base;
  logic [31:0] tod_diff;
  logic [16:0] wk_sum;
  logic [33:0] wk_prod;
  logic [16:0] wk_base;
  logic [16:0] wk_diff;
  logic [26:0] hour_prod;
  logic [16:0] hour_base;
  logic [16:0] mrem_diff;
  logic [20:0] min_prod;
  logic [11:0] min_base;
  logic [11:0] sec_diff;

  logic        leap;
  logic [8:0]  ylen;
  logic        year_done;
  logic [8:0]  yday;
  logic [8:0]  dadj;
  logic [3:0]  midx;
  logic [4:0]  mday_base;
  logic [3:0]  month_nxt;
  logic [4:0]  mday_nxt;

  always_comb begin
    day_prod  = 51'(secs_r[31:7]) * 51'(esud_pkg::DayRecip);
    day_base  = 32'(days_r) * esud_pkg::SecsPerDay;
    tod_diff  = secs_r - day_base;
    wk_sum    = {1'b0, days_r} + {13'd0, esud_pkg::WdayOffset};
    wk_prod   = 34'(wk_sum) * 34'(esud_pkg::WeekRecip);
    wk_base   = {3'd0, wq_r} * 17'(esud_pkg::DaysPerWeek);
    wk_diff   = wk_sum - wk_base;
    hour_prod = 27'(tod_r[16:4]) * 27'(esud_pkg::HourRecip);
    hour_base = {12'd0, hour_r} * 17'(esud_pkg::SecsPerHour);
    mrem_diff = tod_r - hour_base;
    min_prod  = 21'(mrem_r[11:2]) * 21'(esud_pkg::MinRecip);
    min_base  = {6'd0, min_r} * 12'(esud_pkg::SecsPerMin);
    sec_diff  = mrem_r - min_base;
  end

  always_comb begin
    leap      = (year_r[1:0] == 2'd0) && ((y100_r != 7'd0) || (y400_r == 9'd0));
    ylen      = leap ? esud_pkg::LeapYearLen : esud_pkg::YearLen;
    year_done = days_r < {7'd0, ylen};
    yday      = days_r[8:0];
    dadj      = (leap && (yday > esud_pkg::LastNoLeapDay)) ? yday - 9'd1 : yday;
    midx      = esud_pkg::month_index(dadj);
    mday_base = (leap && (yday == esud_pkg::LeapDay)) ? 5'd2 : 5'd1;
    month_nxt = midx + 4'd1;
    mday_nxt  = 5'(dadj - esud_pkg::month_start(midx)) + mday_base;
  end

  assign sts.year_done = year_done;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      secs_r <= in_epoch_seconds;
    end else if (cmd.day_div) begin
      days_r <= day_prod[50:35];
    end else if (cmd.tod_split) begin
      tod_r <= tod_diff[16:0];
      wq_r  <= wk_prod[32:19];
    end else if (cmd.hour_div) begin
      hour_r <= hour_prod[25:21];
      wday_r <= wk_diff[2:0];
    end else if (cmd.min_rem) begin
      mrem_r <= mrem_diff[11:0];
    end else if (cmd.min_div) begin
      min_r <= min_prod[19:14];
    end else if (cmd.to_year) begin
      sec_r  <= sec_diff[5:0];
      year_r <= esud_pkg::EpochYear;
      y100_r <= esud_pkg::EpochYear100;
      y400_r <= esud_pkg::EpochYear400;
    end else if (cmd.year_step && !year_done) begin
      days_r <= days_r - {7'd0, ylen};
      year_r <= year_r + 12'd1;
      y100_r <= (y100_r == esud_pkg::Cycle100Last) ? 7'd0 : y100_r + 7'd1;
      y400_r <= (y400_r == esud_pkg::Cycle400Last) ? 9'd0 : y400_r + 9'd1;
    end else if (cmd.finish) begin
      month_r <= month_nxt;
      mday_r  <= mday_nxt;
    end
  end

  assign second        = sec_r;
  assign minute        = min_r;
  assign hour          = hour_r;
  assign weekday       = wday_r;
  assign calendar_year = year_r;
  assign day_of_year   = yday;
  assign month         = month_r;
  assign day_of_month  = mday_r;

endmodule

FILE: design/esud_ctrl.sv
// ----------------------------------------------------------------------------
// esud_ctrl: controller
// sequences the day, hour and minute splits, the year walk and the month lookup
// ----------------------------------------------------------------------------
module esud_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  esud_pkg::esud_sts_t  sts,
  output esud_pkg::esud_cmd_t  cmd,
  output logic                 busy,
  output logic                 done
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DAY,
    S_TOD,
    S_HOUR,
    S_MREM,
    S_MIN,
    S_YSET,
    S_YEAR,
    S_MONTH
  } state_t;

  state_t                        state_r;
  logic                          done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) state_r <= S_DAY;
        end
        S_DAY:  state_r <= S_TOD;
        S_TOD:  state_r <= S_HOUR;
        S_HOUR: state_r <= S_MREM;
        S_MREM: state_r <= S_MIN;
        S_MIN:  state_r <= S_YSET;
        S_YSET: state_r <= S_YEAR;
        S_YEAR: begin
          if (sts.year_done) state_r <= S_MONTH;
        end
        S_MONTH: begin
          state_r <= S_IDLE;
          done_r  <= 1'b1;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.load      = (state_r == S_IDLE) && start;
    cmd.day_div   = state_r == S_DAY;
    cmd.tod_split = state_r == S_TOD;
    cmd.hour_div  = state_r == S_HOUR;
    cmd.min_rem   = state_r == S_MREM;
    cmd.min_div   = state_r == S_MIN;
    cmd.to_year   = state_r == S_YSET;
    cmd.year_step = state_r == S_YEAR;
    cmd.finish    = state_r == S_MONTH;
  end

  assign busy = state_r != S_IDLE;
  assign done = done_r;

endmodule
